FILE: rtl/ps2kd_pkg.sv
// Shared types and constants for the PS/2 set-1 scancode decoder.
// No dependencies.
`timescale 1ns / 1ps

package ps2kd_pkg;

   localparam logic [1:0] FUNC_SCAN = 2'd0;
   localparam logic [1:0] FUNC_POP  = 2'd1;
   localparam logic [1:0] FUNC_MAP  = 2'd2;

   localparam logic [7:0] SC_F12_MAKE  = 8'h58;
   localparam logic [7:0] SC_F12_BREAK = 8'hD8;
   localparam logic [7:0] SC_PREFIX    = 8'hE0;
   localparam logic [6:0] KEY_LSHIFT   = 7'h2A;
   localparam logic [6:0] KEY_RSHIFT   = 7'h36;
   localparam logic [6:0] KEY_CAPS     = 7'h3A;
   localparam logic [6:0] KEY_CTRL     = 7'h1D;
   localparam logic [6:0] KEY_ALT      = 7'h38;

   localparam int KEY_BITS = 7;
   localparam int MAP_BITS = 9;

   // One ring entry: kind, character, special code.
   typedef struct packed {
      logic       kind;
      logic [7:0] ch;
      logic [3:0] special;
   } event_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_LOOKUP,
      ST_FALLBACK,
      ST_DEBUG,
      ST_POP
   } state_type;

   function automatic logic [3:0] ext_special(input logic [6:0] key);
      case (key)
         7'h48: ext_special = 4'd1;
         7'h50: ext_special = 4'd2;
         7'h4B: ext_special = 4'd3;
         7'h4D: ext_special = 4'd4;
         7'h47: ext_special = 4'd5;
         7'h4F: ext_special = 4'd6;
         7'h49: ext_special = 4'd7;
         7'h51: ext_special = 4'd8;
         7'h52: ext_special = 4'd9;
         7'h53: ext_special = 4'd10;
         default: ext_special = 4'd0;
      endcase
   endfunction

   function automatic logic [7:0] hex_char(input logic [3:0] v);
      if (v < 4'd10) begin
         hex_char = 8'h30 + {4'd0, v};
      end else begin
         hex_char = 8'h57 + {4'd0, v};
      end
   endfunction

endpackage

FILE: rtl/ps2_scancode_to_key_event.sv
// PS/2 set-1 scancode decoder: top level with control sequencer.
// Depends on ps2kd_pkg, ps2kd_keymap and ps2kd_ring.
`timescale 1ns / 1ps

// After reset the block clears all 512 keymap entries, with busy high.
// A keymap write or an ignored byte is handled in the idle state, a
// translated key takes a keymap read, plus a second read for the altgr
// fallback, and a pop a ring read. A debug-mode press pushes '[', "E0 "
// if the prefix came before it, the two hex digits of the key and ']'.
// The response of a pop appears on rsp_strobe for one cycle and cannot be
// held off by the receiver.
module ps2_scancode_to_key_event
   import ps2kd_pkg::*;
#(
   parameter int RING_DEPTH = 128
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_func,
   input  logic [7:0]  req_scan_byte,
   input  logic [1:0]  req_map_select,
   input  logic [6:0]  req_map_index,
   input  logic [7:0]  req_map_char,
   output logic        rsp_strobe,
   output logic        rsp_event_valid,
   output logic        rsp_event_kind,
   output logic [7:0]  rsp_event_char,
   output logic [3:0]  rsp_special_code,
   output logic [31:0] rsp_drop_total
);

   localparam int PTR_BITS = (RING_DEPTH > 2) ? $clog2(RING_DEPTH) : 1;

   state_type state_ff, state_in;
   logic [MAP_BITS-1:0] clr_ff, clr_in;
   logic [PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in, wr_ptr_ff, wr_ptr_in;
   logic [31:0] drop_ff, drop_in;
   logic shift_ff, shift_in, ctrl_ff, ctrl_in, alt_ff, alt_in;
   logic altgr_ff, altgr_in, caps_ff, caps_in, prefix_ff, prefix_in;
   logic debug_ff, debug_in;
   logic [6:0] key_ff, key_in;
   logic [2:0] dstep_ff, dstep_in;
   logic dbg_pre_ff, dbg_pre_in;

   logic                km_we;
   logic [MAP_BITS-1:0] km_waddr, km_raddr;
   logic [7:0]          km_wdata, km_rdata;
   logic                rg_we;
   event_type           rg_wdata, rg_rdata;

   logic push;
   event_type push_ev;
   logic [PTR_BITS-1:0] wr_next;
   logic alt_any;
   logic [7:0] ch;
   logic [6:0] in_key;
   logic in_rel;
   logic accept;

   ps2kd_keymap u_keymap (
      .clock(clock), .wr_en(km_we), .wr_addr(km_waddr), .wr_data(km_wdata),
      .rd_addr(km_raddr), .rd_data(km_rdata)
   );

   ps2kd_ring #(.DEPTH(RING_DEPTH), .PTR_BITS(PTR_BITS)) u_ring (
      .clock(clock), .wr_en(rg_we), .wr_addr(wr_ptr_ff), .wr_data(rg_wdata),
      .rd_addr(rd_ptr_ff), .rd_data(rg_rdata)
   );

   assign busy    = (state_ff != ST_IDLE);
   assign accept  = start && !busy;
   assign in_key  = req_scan_byte[6:0];
   assign in_rel  = req_scan_byte[7];
   assign alt_any = alt_ff || altgr_ff;

   always_comb begin
      if (wr_ptr_ff == PTR_BITS'(RING_DEPTH - 1)) begin
         wr_next = '0;
      end else begin
         wr_next = wr_ptr_ff + 1'b1;
      end
   end

   // Character post-processing: ctrl letters and caps lock.
   always_comb begin
      ch = km_rdata;
      if (ctrl_ff && !alt_any && km_rdata >= 8'h61 && km_rdata <= 8'h7A) begin
         ch = km_rdata - 8'h60;
      end else if (ctrl_ff && !alt_any && km_rdata >= 8'h41 && km_rdata <= 8'h5A) begin
         ch = km_rdata - 8'h40;
      end else if (!alt_any && !shift_ff && caps_ff &&
                   km_rdata >= 8'h61 && km_rdata <= 8'h7A) begin
         ch = km_rdata - 8'h20;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clr_ff == '1) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (accept && req_func == FUNC_POP) begin
               state_in = ST_POP;
            end else if (accept && req_func == FUNC_SCAN &&
                         req_scan_byte != SC_F12_MAKE && req_scan_byte != SC_F12_BREAK) begin
               if (debug_ff) begin
                  if (!in_rel) state_in = ST_DEBUG;
               end else if (!prefix_ff && !in_rel && in_key != KEY_LSHIFT &&
                            in_key != KEY_RSHIFT && in_key != KEY_CAPS &&
                            in_key != KEY_CTRL && in_key != KEY_ALT) begin
                  state_in = ST_LOOKUP;
               end
            end
         end
         ST_LOOKUP: begin
            if (alt_any && shift_ff && km_rdata == 8'd0) state_in = ST_FALLBACK;
            else state_in = ST_IDLE;
         end
         ST_FALLBACK: state_in = ST_IDLE;
         ST_DEBUG: begin
            if (dstep_ff == 3'd7) state_in = ST_IDLE;
         end
         ST_POP: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // Datapath and outputs.
   always_comb begin
      clr_in = clr_ff; rd_ptr_in = rd_ptr_ff; drop_in = drop_ff;
      shift_in = shift_ff; ctrl_in = ctrl_ff; alt_in = alt_ff;
      altgr_in = altgr_ff; caps_in = caps_ff; prefix_in = prefix_ff;
      debug_in = debug_ff; key_in = key_ff; dstep_in = dstep_ff;
      dbg_pre_in = dbg_pre_ff;
      km_we = 1'b0; km_waddr = {req_map_select, req_map_index}; km_wdata = req_map_char;
      km_raddr = {2'd0, in_key};
      push = 1'b0; push_ev = '0;
      rsp_strobe = 1'b0; rsp_event_valid = 1'b0; rsp_event_kind = 1'b0;
      rsp_event_char = 8'd0; rsp_special_code = 4'd0;
      case (state_ff)
         ST_CLEAR: begin
            km_we = 1'b1; km_waddr = clr_ff; km_wdata = 8'd0;
            clr_in = clr_ff + 1'b1;
         end
         ST_IDLE: begin
            if (accept && req_func == FUNC_MAP) begin
               km_we = 1'b1;
            end else if (accept && req_func == FUNC_SCAN) begin
               key_in = in_key;
               if (alt_any && shift_ff) km_raddr = {2'd3, in_key};
               else if (alt_any) km_raddr = {2'd2, in_key};
               else if (shift_ff) km_raddr = {2'd1, in_key};
               if (req_scan_byte == SC_F12_MAKE) begin
                  debug_in = !debug_ff;
               end else if (req_scan_byte == SC_F12_BREAK) begin
                  debug_in = debug_ff;
               end else if (debug_ff) begin
                  if (!in_rel) begin
                     dbg_pre_in = prefix_ff;
                     prefix_in = 1'b0;
                     dstep_in = 3'd0;
                  end
               end else if (req_scan_byte == SC_PREFIX) begin
                  prefix_in = 1'b1;
               end else if (prefix_ff) begin
                  prefix_in = 1'b0;
                  if (in_key == KEY_ALT) altgr_in = !in_rel;
                  else if (in_key == KEY_CTRL) ctrl_in = !in_rel;
                  else if (!in_rel && ext_special(in_key) != 4'd0) begin
                     push = 1'b1;
                     push_ev.kind = 1'b1;
                     push_ev.special = ext_special(in_key);
                  end
               end else if (in_key == KEY_LSHIFT || in_key == KEY_RSHIFT) begin
                  shift_in = !in_rel;
               end else if (in_key == KEY_CAPS) begin
                  if (!in_rel) caps_in = !caps_ff;
               end else if (in_key == KEY_CTRL) begin
                  ctrl_in = !in_rel;
               end else if (in_key == KEY_ALT) begin
                  alt_in = !in_rel;
               end
            end
         end
         ST_LOOKUP: begin
            km_raddr = {2'd2, key_ff};
            if (km_rdata != 8'd0) begin
               push = 1'b1; push_ev.ch = ch;
            end
         end
         ST_FALLBACK: begin
            if (km_rdata != 8'd0) begin
               push = 1'b1; push_ev.ch = ch;
            end
         end
         ST_DEBUG: begin
            // Steps: '[', 'E', '0', ' ', high digit, low digit, ']'; without the prefix 'E', '0', ' ' are skipped.
            push = 1'b1;
            case (dstep_ff)
               3'd0: push_ev.ch = 8'h5B;
               3'd1: push_ev.ch = 8'h45;
               3'd2: push_ev.ch = 8'h30;
               3'd3: push_ev.ch = 8'h20;
               3'd4: push_ev.ch = hex_char({1'b0, key_ff[6:4]});
               3'd5: push_ev.ch = hex_char(key_ff[3:0]);
               default: push_ev.ch = 8'h5D;
            endcase
            if (dstep_ff == 3'd0 && !dbg_pre_ff) dstep_in = 3'd4;
            else dstep_in = dstep_ff + 1'b1;
            if (dstep_ff == 3'd7) push = 1'b0;
         end
         ST_POP: begin
            rsp_strobe = 1'b1;
            if (rd_ptr_ff != wr_ptr_ff) begin
               rsp_event_valid = 1'b1;
               rsp_event_kind = rg_rdata.kind;
               rsp_event_char = rg_rdata.ch;
               rsp_special_code = rg_rdata.special;
               if (rd_ptr_ff == PTR_BITS'(RING_DEPTH - 1)) rd_ptr_in = '0;
               else rd_ptr_in = rd_ptr_ff + 1'b1;
            end
         end
         default: ;
      endcase
      rg_we = push && (wr_next != rd_ptr_ff);
      rg_wdata = push_ev;
      wr_ptr_in = rg_we ? wr_next : wr_ptr_ff;
      if (push && !rg_we) drop_in = drop_ff + 32'd1;
   end

   assign rsp_drop_total = drop_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR; clr_ff <= '0; rd_ptr_ff <= '0; wr_ptr_ff <= '0;
         drop_ff <= '0; shift_ff <= 1'b0; ctrl_ff <= 1'b0; alt_ff <= 1'b0;
         altgr_ff <= 1'b0; caps_ff <= 1'b0; prefix_ff <= 1'b0; debug_ff <= 1'b0;
         dstep_ff <= '0; dbg_pre_ff <= 1'b0;
      end else begin
         state_ff <= state_in; clr_ff <= clr_in; rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in; drop_ff <= drop_in; shift_ff <= shift_in;
         ctrl_ff <= ctrl_in; alt_ff <= alt_in; altgr_ff <= altgr_in;
         caps_ff <= caps_in; prefix_ff <= prefix_in; debug_ff <= debug_in;
         dstep_ff <= dstep_in; dbg_pre_ff <= dbg_pre_in;
      end
      key_ff <= key_in;
   end

endmodule

FILE: rtl/ps2kd_keymap.sv
// Keymap memory: 4 x 128 characters, synchronous read.
// Depends on ps2kd_pkg.
`timescale 1ns / 1ps

module ps2kd_keymap
   import ps2kd_pkg::*;
(
   input  logic                clock,
   input  logic                wr_en,
   input  logic [MAP_BITS-1:0] wr_addr,
   input  logic [7:0]          wr_data,
   input  logic [MAP_BITS-1:0] rd_addr,
   output logic [7:0]          rd_data
);

   logic [7:0] mem [0:(1 << MAP_BITS)-1];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/ps2kd_ring.sv
// Event ring memory with synchronous read.
// Depends on ps2kd_pkg.
`timescale 1ns / 1ps

module ps2kd_ring
   import ps2kd_pkg::*;
#(
   parameter int DEPTH = 128,
   parameter int PTR_BITS = 7
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [PTR_BITS-1:0] wr_addr,
   input  event_type           wr_data,
   input  logic [PTR_BITS-1:0] rd_addr,
   output event_type           rd_data
);

   event_type mem [0:DEPTH-1];
   event_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/ps2kd_checker.sv
// Port-level checks for the scancode decoder, bound to the top level.
// Depends on ps2kd_pkg and ps2_scancode_to_key_event.
`timescale 1ns / 1ps

module ps2kd_checker
   import ps2kd_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic [1:0]  req_func,
   input logic        rsp_strobe,
   input logic        rsp_event_valid,
   input logic        rsp_event_kind,
   input logic [7:0]  rsp_event_char,
   input logic [3:0]  rsp_special_code,
   input logic [31:0] rsp_drop_total
);

   a_pop_resp: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_func == FUNC_POP) |=> rsp_strobe)
      else $error("pop without response");

   a_strobe_only_pop: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy && req_func == FUNC_POP))
      else $error("response without pending item");

   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_event_valid) |->
         (!rsp_event_kind && rsp_event_char == 8'd0 && rsp_special_code == 4'd0))
      else $error("empty pop carries data");

   a_kind_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_event_valid && rsp_event_kind) |-> rsp_event_char == 8'd0)
      else $error("special event carries a character");

endmodule

bind ps2_scancode_to_key_event ps2kd_checker u_checker (.*);
